>>> rtl/core/rht_pkg.sv
// Package for the ranked hit table: entry and channel payload types,
// result status codes, sequencer states and fixed field limits.
// No dependencies.
package rht_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;

    localparam logic [7:0]  WORDS_MAX = 8'hFF;
    localparam logic [23:0] HITS_MAX  = 24'hFF_FFFF;

    typedef struct packed {
        logic [9:0]  doc_id;
        logic [7:0]  words;
        logic [23:0] hits;
    } t_entry;

    typedef enum logic {
        OP_ADD  = 1'b0,
        OP_READ = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        STAT_UPDATED    = 3'd0,
        STAT_INSERTED   = 3'd1,
        STAT_FULL       = 3'd2,
        STAT_READ_OK    = 3'd3,
        STAT_READ_EMPTY = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_BSTART,
        S_BUBBLE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic        operation;
        logic [9:0]  doc_id;
        logic [15:0] hit_count;
        logic [5:0]  rank_index;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [9:0]  out_doc_id;
        logic [7:0]  words_matched;
        logic [23:0] total_hits;
        logic [5:0]  position;
        logic [6:0]  entries_used;
    } t_rsp;

endpackage

>>> rtl/core/rht_ifs.sv
// Valid/ready channel interfaces for the ranked hit table.
// Depends on rht_pkg for the payload structs.
interface rht_req_if;
    logic          valid;
    logic          ready;
    rht_pkg::t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface rht_rsp_if;
    logic          valid;
    logic          ready;
    rht_pkg::t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/core/rht_mem.sv
// Entry store of the ranked hit table: one write port, one read port,
// registered read data. Depends on rht_pkg for the entry type.
module rht_mem #(
    parameter int DEPTH = rht_pkg::TABLE_ENTRIES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  rht_pkg::t_entry i_wdata,
    input  logic            i_re,
    input  logic [AW-1:0]   i_raddr,
    output rht_pkg::t_entry o_rdata
);

    rht_pkg::t_entry r_mem [DEPTH];
    rht_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/ranked_hit_table.sv
// Top level of the ranked hit table: sequencer, entry store and result register.
// Depends on rht_pkg, rht_ifs (channels) and rht_mem.
//
//   channel | dir | payload fields
//   --------+-----+------------------------------------------------------------
//   i_req   | in  | operation, doc_id, hit_count, rank_index
//   o_rsp   | out | status, out_doc_id, words_matched, total_hits, position,
//           |     | entries_used
//
// Read: the store is read as the request is taken and the result is loaded
// from its data. Add: a lookup scan, then the entry bubbles forward past
// smaller ones. Both the lookup scan and the bubbling run at one entry per
// cycle through the single read port of the entry store. Reset clears the
// state, the entry count and the valid flags; the store needs no clearing pass.
// One item at a time; a new item is taken while a result still waits in o_rsp.
module ranked_hit_table #(
    parameter int TABLE_ENTRIES = rht_pkg::TABLE_ENTRIES_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    rht_req_if.sink   i_req,
    rht_rsp_if.source o_rsp
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;

    rht_pkg::t_state  r_state, n_state;
    logic [CNT_W-1:0] r_used, n_used;
    logic [CNT_W-1:0] r_scan, n_scan;
    logic             r_cmp_vld, n_cmp_vld;
    logic [IDX_W-1:0] r_cmp_idx, n_cmp_idx;
    logic [IDX_W-1:0] r_pos, n_pos;
    rht_pkg::t_entry  r_ent, n_ent;
    rht_pkg::t_status r_status, n_status;
    logic [9:0]       r_id, n_id;
    logic [15:0]      r_hc, n_hc;
    logic [5:0]       r_rk, n_rk;
    logic             r_out_vld, n_out_vld;
    rht_pkg::t_rsp    r_out, n_out;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    rht_pkg::t_entry  mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;
    rht_pkg::t_entry  mem_rdata;

    logic             accept;
    logic             out_free;
    logic [CMP_W-1:0] rk_ext;
    logic             rd_in_range;
    logic             hit;
    logic [24:0]      hit_sum;
    logic             less;
    logic [IDX_W-1:0] pos_m1;
    logic [IDX_W-1:0] pos_m2;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] used_ext;

    rht_mem #(
        .DEPTH (TABLE_ENTRIES),
        .AW    (IDX_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign i_req.ready   = (r_state == rht_pkg::S_IDLE);
    assign accept        = i_req.valid && i_req.ready;
    assign o_rsp.valid   = r_out_vld;
    assign o_rsp.payload = r_out;
    assign out_free      = !r_out_vld || o_rsp.ready;

    assign rk_ext      = CMP_W'(i_req.payload.rank_index);
    assign rd_in_range = (rk_ext < CMP_W'(r_used)) && (rk_ext < CMP_W'(TABLE_ENTRIES));
    assign hit         = r_cmp_vld && (mem_rdata.doc_id == r_id);
    assign hit_sum     = {1'b0, mem_rdata.hits} + 25'(r_hc);
    // front entry loses its place only to a strictly larger key
    assign less   = (mem_rdata.words < r_ent.words) ||
                    ((mem_rdata.words == r_ent.words) && (mem_rdata.hits < r_ent.hits));
    assign pos_m1   = r_pos - IDX_W'(1);
    assign pos_m2   = r_pos - IDX_W'(2);
    assign pos_ext  = CMP_W'(r_pos);
    assign used_ext = CMP_W'(r_used);

    always_comb begin
        n_state   = r_state;
        n_used    = r_used;
        n_scan    = r_scan;
        n_cmp_vld = r_cmp_vld;
        n_cmp_idx = r_cmp_idx;
        n_pos     = r_pos;
        n_ent     = r_ent;
        n_status  = r_status;
        n_id      = r_id;
        n_hc      = r_hc;
        n_rk      = r_rk;
        n_out_vld = r_out_vld;
        n_out     = r_out;
        mem_we    = 1'b0;
        mem_waddr = r_pos;
        mem_wdata = r_ent;
        mem_re    = 1'b0;
        mem_raddr = r_scan[IDX_W-1:0];

        if (o_rsp.ready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            rht_pkg::S_IDLE: begin
                if (accept) begin
                    n_id      = i_req.payload.doc_id;
                    n_hc      = i_req.payload.hit_count;
                    n_rk      = i_req.payload.rank_index;
                    n_scan    = '0;
                    n_cmp_vld = 1'b0;
                    if (i_req.payload.operation == rht_pkg::OP_READ) begin
                        n_state = rht_pkg::S_DONE;
                        if (rd_in_range) begin
                            mem_re    = 1'b1;
                            mem_raddr = rk_ext[IDX_W-1:0];
                            n_status  = rht_pkg::STAT_READ_OK;
                        end else begin
                            n_status  = rht_pkg::STAT_READ_EMPTY;
                        end
                    end else begin
                        n_state = rht_pkg::S_SEARCH;
                    end
                end
            end

            rht_pkg::S_SEARCH: begin
                if (hit) begin
                    n_cmp_vld     = 1'b0;
                    n_pos         = r_cmp_idx;
                    n_ent.doc_id  = mem_rdata.doc_id;
                    n_ent.words   = (mem_rdata.words == rht_pkg::WORDS_MAX) ?
                                    rht_pkg::WORDS_MAX : mem_rdata.words + 8'd1;
                    n_ent.hits    = hit_sum[24] ? rht_pkg::HITS_MAX : hit_sum[23:0];
                    n_status      = rht_pkg::STAT_UPDATED;
                    n_state       = rht_pkg::S_BSTART;
                end else if (r_scan < r_used) begin
                    // one read per cycle; compare uses the registered read data
                    mem_re    = 1'b1;
                    mem_raddr = r_scan[IDX_W-1:0];
                    n_cmp_idx = r_scan[IDX_W-1:0];
                    n_cmp_vld = 1'b1;
                    n_scan    = r_scan + CNT_W'(1);
                end else if (r_cmp_vld) begin
                    n_cmp_vld = 1'b0;
                end else if (r_used == CNT_W'(TABLE_ENTRIES)) begin
                    n_status = rht_pkg::STAT_FULL;
                    n_state  = rht_pkg::S_DONE;
                end else begin
                    n_pos        = r_used[IDX_W-1:0];
                    n_ent.doc_id = r_id;
                    n_ent.words  = 8'd1;
                    n_ent.hits   = 24'(r_hc);
                    n_used       = r_used + CNT_W'(1);
                    n_status     = rht_pkg::STAT_INSERTED;
                    n_state      = rht_pkg::S_BSTART;
                end
            end

            rht_pkg::S_BSTART: begin
                if (r_pos == '0) begin
                    mem_we  = 1'b1;
                    n_state = rht_pkg::S_DONE;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = pos_m1;
                    n_state   = rht_pkg::S_BUBBLE;
                end
            end

            rht_pkg::S_BUBBLE: begin
                // moving entry stays in r_ent; each passed entry is written back, r_ent once it stops
                if (less) begin
                    mem_we    = 1'b1;
                    mem_wdata = mem_rdata;
                    n_pos     = pos_m1;
                    if (pos_m1 == '0) begin
                        n_state = rht_pkg::S_BSTART;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = pos_m2;
                    end
                end else begin
                    mem_we  = 1'b1;
                    n_state = rht_pkg::S_DONE;
                end
            end

            rht_pkg::S_DONE: begin
                if (out_free) begin
                    n_out_vld                = 1'b1;
                    n_out.status             = r_status;
                    n_out.entries_used       = used_ext[6:0];
                    n_state                  = rht_pkg::S_IDLE;
                    case (r_status)
                        rht_pkg::STAT_READ_OK: begin
                            n_out.out_doc_id    = mem_rdata.doc_id;
                            n_out.words_matched = mem_rdata.words;
                            n_out.total_hits    = mem_rdata.hits;
                            n_out.position      = r_rk;
                        end
                        rht_pkg::STAT_READ_EMPTY: begin
                            n_out.out_doc_id    = '0;
                            n_out.words_matched = '0;
                            n_out.total_hits    = '0;
                            n_out.position      = r_rk;
                        end
                        rht_pkg::STAT_FULL: begin
                            n_out.out_doc_id    = r_id;
                            n_out.words_matched = '0;
                            n_out.total_hits    = '0;
                            n_out.position      = '0;
                        end
                        rht_pkg::STAT_UPDATED, rht_pkg::STAT_INSERTED: begin
                            n_out.out_doc_id    = r_ent.doc_id;
                            n_out.words_matched = r_ent.words;
                            n_out.total_hits    = r_ent.hits;
                            n_out.position      = pos_ext[5:0];
                        end
                        default: begin
                            n_out.out_doc_id    = '0;
                            n_out.words_matched = '0;
                            n_out.total_hits    = '0;
                            n_out.position      = '0;
                        end
                    endcase
                end
            end

            default: begin
                n_state = rht_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rht_pkg::S_IDLE;
            r_used    <= '0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_used    <= n_used;
            r_cmp_vld <= n_cmp_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan    <= n_scan;
        r_cmp_idx <= n_cmp_idx;
        r_pos     <= n_pos;
        r_ent     <= n_ent;
        r_status  <= n_status;
        r_id      <= n_id;
        r_hc      <= n_hc;
        r_rk      <= n_rk;
        r_out     <= n_out;
    end

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        used_ext <= CMP_W'(TABLE_ENTRIES))
        else $error("entry count above table size");

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rht_pkg::S_SEARCH || r_state == rht_pkg::S_IDLE) |-> !mem_we)
        else $error("store written during lookup or idle");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> $past(r_state == rht_pkg::S_DONE))
        else $error("result raised outside the done state");

    a_used_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != rht_pkg::S_SEARCH) |=> (r_used == $past(r_used)))
        else $error("entry count changed outside lookup");

endmodule
